FILE: sv/prsrl_pkg.sv
// shared types, codes and constants of the per-source receive rate limiter
`default_nettype none

package prsrl_pkg;

  localparam int          TABLE_DEPTH_DEF  = 16;
  localparam logic [31:0] MIN_INTERVAL_RST = 32'd10000;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [2:0] OUT_KNOWN   = 3'd0;
  localparam logic [2:0] OUT_LIMITED = 3'd1;
  localparam logic [2:0] OUT_ADDED   = 3'd2;
  localparam logic [2:0] OUT_EVICTED = 3'd3;
  localparam logic [2:0] OUT_CLEARED = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [31:0] peer_addr;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic       allowed;
    logic [2:0] outcome;
  } out_t;

  // search token that walks the cell row
  typedef struct packed {
    logic        valid;
    logic [31:0] peer_addr;
    logic [31:0] now_ms;
    logic        found;
    logic        limited;
    logic [31:0] old_stamp;
  } scan_tok_t;

  // write-back broadcast to the cells
  typedef struct packed {
    logic        en;
    logic [31:0] peer_addr;
    logic [31:0] stamp;
  } cell_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } ctrl_state_t;

endpackage

`default_nettype wire

FILE: sv/prsrl_cell.sv
// one table entry with its stage of the lookup / oldest-search chain
`default_nettype none

module prsrl_cell #(
  parameter int  TABLE_DEPTH = prsrl_pkg::TABLE_DEPTH_DEF,
  parameter int  CELL_IDX    = 0,
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           min_interval,
  input  logic [CNT_W-1:0]      entry_count,
  input  prsrl_pkg::scan_tok_t  tok_i,
  input  logic [IDX_W-1:0]      hit_idx_i,
  input  logic [IDX_W-1:0]      old_idx_i,
  output prsrl_pkg::scan_tok_t  tok_o,
  output logic [IDX_W-1:0]      hit_idx_o,
  output logic [IDX_W-1:0]      old_idx_o,
  input  prsrl_pkg::cell_wr_t   wr,
  input  logic [IDX_W-1:0]      wr_idx
);
  import prsrl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  logic [31:0]      src_r;
  logic [31:0]      stamp_r;
  scan_tok_t        tok_r, tok_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] old_idx_r, old_idx_nxt;
  logic             entry_valid;
  logic             match;
  logic [31:0]      elapsed;

  assign entry_valid = MY_CNT < entry_count;
  assign match       = tok_i.valid && entry_valid && !tok_i.found &&
                       (src_r == tok_i.peer_addr);
  assign elapsed     = tok_i.now_ms - stamp_r;

  always_comb begin
    tok_nxt     = tok_i;
    hit_idx_nxt = hit_idx_i;
    old_idx_nxt = old_idx_i;
    // first matching entry wins
    if (match) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.limited = elapsed < min_interval;
      hit_idx_nxt     = MY_IDX;
    end
    // strict compare keeps the lowest index on a tie
    if ((CELL_IDX == 0) || (stamp_r < tok_i.old_stamp)) begin
      tok_nxt.old_stamp = stamp_r;
      old_idx_nxt       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r <= hit_idx_nxt;
    old_idx_r <= old_idx_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == MY_IDX)) begin
      src_r   <= wr.peer_addr;
      stamp_r <= wr.stamp;
    end
  end

  assign tok_o     = tok_r;
  assign hit_idx_o = hit_idx_r;
  assign old_idx_o = old_idx_r;

endmodule

`default_nettype wire

FILE: sv/prsrl_ctrl.sv
// sequencer: accepts transactions, launches the scan, writes back, holds results
`default_nettype none

module prsrl_ctrl #(
  parameter int  TABLE_DEPTH = prsrl_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  prsrl_pkg::in_t        in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output prsrl_pkg::out_t       out_data,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata,
  output logic [31:0]           min_interval,
  output logic [CNT_W-1:0]      entry_count,
  output prsrl_pkg::scan_tok_t  launch_tok,
  input  prsrl_pkg::scan_tok_t  last_tok,
  input  logic [IDX_W-1:0]      last_hit_idx,
  input  logic [IDX_W-1:0]      last_old_idx,
  output prsrl_pkg::cell_wr_t   wr,
  output logic [IDX_W-1:0]      wr_idx
);
  import prsrl_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  out_t             res_r, res_nxt;
  scan_tok_t        launch_r, launch_nxt;
  logic             out_valid_r;
  out_t             out_data_r;
  logic [31:0]      min_r;
  logic             out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    res_nxt          = res_r;
    launch_nxt       = launch_r;
    launch_nxt.valid = 1'b0;
    wr               = '0;
    wr_idx           = '0;
    out_load         = 1'b0;
    in_stall         = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_data.opcode == OP_CLEAR) begin
            count_nxt       = '0;
            res_nxt.allowed = 1'b0;
            res_nxt.outcome = OUT_CLEARED;
            state_nxt       = ST_HOLD;
          end else begin
            launch_nxt.valid     = 1'b1;
            launch_nxt.peer_addr = in_data.peer_addr;
            launch_nxt.now_ms    = in_data.now_ms;
            launch_nxt.found     = 1'b0;
            launch_nxt.limited   = 1'b0;
            launch_nxt.old_stamp = '0;
            state_nxt            = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_tok.valid) begin
          wr.peer_addr = last_tok.peer_addr;
          wr.stamp     = last_tok.now_ms;
          state_nxt    = ST_HOLD;
          if (last_tok.found && last_tok.limited) begin
            res_nxt.allowed = 1'b0;
            res_nxt.outcome = OUT_LIMITED;
          end else if (last_tok.found) begin
            wr.en           = 1'b1;
            wr_idx          = last_hit_idx;
            res_nxt.allowed = 1'b1;
            res_nxt.outcome = OUT_KNOWN;
          end else if (count_r < DEPTH_CNT) begin
            wr.en           = 1'b1;
            wr_idx          = count_r[IDX_W-1:0];
            count_nxt       = count_r + CNT_W'(1);
            res_nxt.allowed = 1'b1;
            res_nxt.outcome = OUT_ADDED;
          end else begin
            wr.en           = 1'b1;
            wr_idx          = last_old_idx;
            res_nxt.allowed = 1'b1;
            res_nxt.outcome = OUT_EVICTED;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
    if (!rst_n) begin
      count_r     <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
      min_r       <= MIN_INTERVAL_RST;
    end else begin
      count_r  <= count_nxt;
      launch_r <= launch_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        min_r <= cfg_wdata;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign min_interval = min_r;
  assign entry_count  = count_r;
  assign launch_tok   = launch_r;

endmodule

`default_nettype wire

FILE: sv/per_source_receive_rate_limiter_top.sv
// top level of the per-source receive rate limiter: sequencer plus a row of table cells
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   in_data   (opcode, peer_addr, now_ms)
//   out_     output     out_valid/out_stall out_data  (allowed, outcome)
//   cfg_     input      cfg_we              cfg_wdata (min_interval)
//
// a check passes through these steps after accept:
//   the launch register loads at the accept edge, then each cell's register in turn as the token
//   walks the row, then the write-back with res_r, then the output register once out_stall allows
// the next transaction is taken once the result has moved into the output register
// a clear goes from accept straight to the hold state and the output register; the cell row is idle
// in_stall is high from accept until the result moves into the output register; a result
//   can wait there under out_stall while the next transaction runs, a second one waits
// synchronous active-low reset empties the table and sets min_interval to 10000; no clearing pass
`default_nettype none

module per_source_receive_rate_limiter_top #(
  parameter int TABLE_DEPTH = prsrl_pkg::TABLE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  prsrl_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output prsrl_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata
);
  import prsrl_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // token chain: element k feeds cell k, element TABLE_DEPTH returns to the sequencer
  scan_tok_t        tok_chain [TABLE_DEPTH+1];
  logic [IDX_W-1:0] hit_chain [TABLE_DEPTH+1];
  logic [IDX_W-1:0] old_chain [TABLE_DEPTH+1];

  logic [31:0]      min_interval;
  logic [CNT_W-1:0] entry_count;
  cell_wr_t         wr;
  logic [IDX_W-1:0] wr_idx;

  // search indexes start at entry zero
  assign hit_chain[0] = '0;
  assign old_chain[0] = '0;

  prsrl_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .min_interval (min_interval),
    .entry_count  (entry_count),
    .launch_tok   (tok_chain[0]),
    .last_tok     (tok_chain[TABLE_DEPTH]),
    .last_hit_idx (hit_chain[TABLE_DEPTH]),
    .last_old_idx (old_chain[TABLE_DEPTH]),
    .wr           (wr),
    .wr_idx       (wr_idx)
  );

  // each cell holds one entry and checks it as the token passes by
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    prsrl_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_IDX    (k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .min_interval (min_interval),
      .entry_count  (entry_count),
      .tok_i        (tok_chain[k]),
      .hit_idx_i    (hit_chain[k]),
      .old_idx_i    (old_chain[k]),
      .tok_o        (tok_chain[k+1]),
      .hit_idx_o    (hit_chain[k+1]),
      .old_idx_o    (old_chain[k+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
  end

endmodule

`default_nettype wire

FILE: sv/prsrl_checker.sv
// port-level checks of the rate limiter, bound to the top level
`default_nettype none

module prsrl_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input prsrl_pkg::out_t out_data
);
  import prsrl_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // allowed agrees with the outcome code
  a_allowed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.allowed == ((out_data.outcome == OUT_KNOWN) ||
                                        (out_data.outcome == OUT_ADDED) ||
                                        (out_data.outcome == OUT_EVICTED))))
    else $error("allowed does not match outcome");

  // outcome is one of the five codes
  a_outcome_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.outcome == OUT_KNOWN) || (out_data.outcome == OUT_LIMITED) ||
                  (out_data.outcome == OUT_ADDED) || (out_data.outcome == OUT_EVICTED) ||
                  (out_data.outcome == OUT_CLEARED))
    else $error("outcome code out of range");

  // one transaction at a time: input stalls right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

  // nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind per_source_receive_rate_limiter_top prsrl_checker u_prsrl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
